[sv/uef_pkg.sv]
// Shared types and constants for the unique-entry FIFO.
// Opcode and status codes, field widths, and the per-cell control struct.
// No dependencies.
package uef_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MIDPOS_W = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_MIDDLE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_FOUND    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  // Per-cell control: shift pulls the neighbor toward the head, load takes the key.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

[sv/unique_entry_fifo_with_middle.sv]
// Top level of the unique-entry FIFO: a chain of uef_cell instances with the head
// in cell 0, request decode and a registered result stage. Depends on uef_pkg, uef_cell.
//
//  channel | dir | tdata                    | tuser
//  --------+-----+--------------------------+----------------
//  in_     | in  | value                    | opcode
//  out_    | out | result_value, mid, count | status
//
// One item per cycle: every cell compares its entry with the request value at
// once, so a request is decoded and applied in the cycle it is accepted and its
// result sits in the output register the next cycle.
// The output register is the only stall point: in_tready drops only while a
// result waits and out_tready is low.
// Synchronous active-low reset empties the queue (all cell valid flags cleared)
// and drops out_tvalid; no clearing pass is needed.
module unique_entry_fifo_with_middle #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] result_value, [35:32] middle_position,
                                  // [40:36] entry_count, [47:41] zero
  output logic [2:0]  out_tuser   // [2:0] status
);
  import uef_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);  // count width
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);      // cell index width

  // Chain state
  logic [CW-1:0]             count_r, count_nxt;
  cell_ctrl_t                ctrl     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    cell_valid;
  logic signed [VALUE_W-1:0] cell_value [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    cell_match;
  logic [QUEUE_DEPTH-1:0]    nb_valid;
  logic signed [VALUE_W-1:0] nb_value [QUEUE_DEPTH];

  // Request decode
  logic                      in_acc;
  op_t                       op;
  logic signed [VALUE_W-1:0] key;
  logic                      hit, empty, full;
  logic                      do_insert, do_remove;
  logic [CW-1:0]             mid;
  logic [IW-1:0]             mid_idx;

  // Result register
  logic                      out_valid_r;
  status_t                   status_r,  status_nxt;
  logic signed [VALUE_W-1:0] rvalue_r,  rvalue_nxt;
  logic [MIDPOS_W-1:0]       midpos_r,  midpos_nxt;
  logic [COUNT_W-1:0]        cnt_out_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign key       = signed'(in_tdata);

  assign hit     = |cell_match;
  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign mid     = count_r >> 1;
  assign mid_idx = mid[IW-1:0];

  assign do_insert = in_acc && (op == OP_INSERT) && !hit && !full;
  assign do_remove = in_acc && (op == OP_REMOVE) && !empty;

  // Neighbor links: each cell takes the entry behind it on a remove.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb_valid[i] = 1'b0;
      assign nb_value[i] = '0;
    end else begin : g_link
      assign nb_valid[i] = cell_valid[i+1];
      assign nb_value[i] = cell_value[i+1];
    end

    // Insert lands in the first free cell, which is at index count.
    assign ctrl[i].shift = do_remove;
    assign ctrl[i].load  = do_insert && (count_r == CW'(i));

    uef_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[i]),
      .key      (key),
      .nb_valid (nb_valid[i]),
      .nb_value (nb_value[i]),
      .valid    (cell_valid[i]),
      .value    (cell_value[i]),
      .match    (cell_match[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rvalue_nxt = '0;
    midpos_nxt = '0;
    unique case (op)
      OP_INSERT: begin
        if (hit) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rvalue_nxt = cell_value[0];
          count_nxt  = count_r - CW'(1);
        end
      end
      OP_SEARCH: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = hit ? ST_FOUND : ST_NOTFOUND;
        end
      end
      OP_MIDDLE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rvalue_nxt = cell_value[mid_idx];
          midpos_nxt = MIDPOS_W'(mid);
        end
      end
      default: begin
        status_nxt = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r <= count_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r  <= status_nxt;
      rvalue_r  <= rvalue_nxt;
      midpos_r  <= midpos_nxt;
      cnt_out_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {7'd0, cnt_out_r, midpos_r, rvalue_r};

  // Valid flags form a packed prefix whose length is the count.
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(cell_valid) == count_r) && (cell_valid[0] || (count_r == '0)))
    else $error("cell valid flags disagree with count");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("count above depth");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r && (cnt_out_r == COUNT_W'(count_r)))
    else $error("result not registered with new count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (status_nxt == ST_FULL)) |=> (count_r == CW'(QUEUE_DEPTH)))
    else $error("full status with room left");

endmodule

[sv/uef_cell.sv]
// One cell of the queue chain: a valid flag, a stored value and an equality compare.
// Depends on uef_pkg.
module uef_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  uef_pkg::cell_ctrl_t              ctrl,
  input  logic signed [uef_pkg::VALUE_W-1:0] key,
  input  logic                             nb_valid,
  input  logic signed [uef_pkg::VALUE_W-1:0] nb_value,
  output logic                             valid,
  output logic signed [uef_pkg::VALUE_W-1:0] value,
  output logic                             match
);
  import uef_pkg::*;

  logic                      valid_r;
  logic signed [VALUE_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= nb_valid;
    end else if (ctrl.load) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value_r <= nb_value;
    end else if (ctrl.load) begin
      value_r <= key;
    end
  end

  assign valid = valid_r;
  assign value = value_r;
  assign match = valid_r && (value_r == key);

endmodule
